// File: sv/sgi_pkg.sv
// Shared types and constants of the softened gravity impulse block.
`timescale 1ns / 1ps
package sgi_pkg;

	localparam int POS_W   = 24;
	localparam int VEL_W   = 32;
	localparam int STEP_W  = 10;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int OFS_W   = 26;
	localparam int MAG_W   = 25;
	localparam int SQ_W    = 50;
	localparam int D2_W    = 51;
	localparam int R2_W    = 48;
	localparam int SP_W    = 34;
	localparam int NUM_W   = 58;
	localparam int ROOT_W  = 26;
	localparam int ACC_QW  = 32;
	localparam int UNIT_QW = 30;
	localparam int UREM_W  = 56;
	localparam int PROD_W  = 64;

	// Stage map of the pipeline
	localparam int ST_FOLD   = 1;
	localparam int ST_SQUARE = 2;
	localparam int ST_CMP    = 3;
	localparam int ST_ITER   = 4;
	localparam int SQ_LAST   = ST_ITER + ROOT_W - 1;
	localparam int ACC_LAST  = ST_ITER + ACC_QW - 1;
	localparam int U_FIRST   = SQ_LAST + 1;
	localparam int U_LAST    = U_FIRST + UNIT_QW - 1;
	localparam int ST_PROD   = U_LAST + 1;
	localparam int ST_SUM    = ST_PROD + 1;
	localparam int PIPE_DEPTH = ST_SUM;

	typedef enum logic [IDX_W-1:0] {
		REG_HOLE_X       = 3'd0,
		REG_HOLE_Y       = 3'd1,
		REG_WORLD_WIDTH  = 3'd2,
		REG_WORLD_HEIGHT = 3'd3,
		REG_HOLE_RADIUS  = 3'd4,
		REG_PULL         = 3'd5,
		REG_REACH        = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]         bx;
		logic [POS_W-1:0]         by;
		logic [STEP_W-1:0]        step;
		logic signed [VEL_W-1:0]  vx;
		logic signed [VEL_W-1:0]  vy;
		logic signed [OFS_W-1:0]  dx;
		logic signed [OFS_W-1:0]  dy;
		logic [SQ_W-1:0]          sqx;
		logic [SQ_W-1:0]          sqy;
		logic [R2_W-1:0]          r2;
		logic [R2_W-1:0]          rr2;
		logic [SP_W-1:0]          sp;
		logic [D2_W-1:0]          d2;
		logic [D2_W-1:0]          soft_d2;
		logic [NUM_W-1:0]         num;
		logic                     bypass;
		logic                     swallowed;
		logic                     in_reach;
		logic [D2_W-1:0]          sq_rem;
		logic [ROOT_W-1:0]        root;
		logic [NUM_W-1:0]         acc_rem;
		logic [ACC_QW-1:0]        acc_q;
		logic                     acc_cap;
		logic [UREM_W-1:0]        ux_rem;
		logic [UREM_W-1:0]        uy_rem;
		logic [UNIT_QW-1:0]       ux_q;
		logic [UNIT_QW-1:0]       uy_q;
		logic                     ux_full;
		logic                     uy_full;
		logic [PROD_W-1:0]        px;
		logic [PROD_W-1:0]        py;
		logic signed [VEL_W-1:0]  vx_out;
		logic signed [VEL_W-1:0]  vy_out;
	} pipe_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic                    swallowed;
		logic                    in_reach;
	} res_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [OFS_W-1:0] d);
		logic signed [OFS_W-1:0] a;
		a = (d < 0) ? -d : d;
		return a[MAG_W-1:0];
	endfunction

	// Add the rounded impulse to a velocity and clamp to the signed range
	function automatic logic signed [VEL_W-1:0] apply_imp(
		input logic signed [VEL_W-1:0] v,
		input logic                    neg,
		input logic [PROD_W-1:0]       prod
	);
		logic [PROD_W-1:0]        rnd;
		logic signed [VEL_W+2:0]  sum;
		logic signed [VEL_W+2:0]  imp;
		rnd = prod + (PROD_W'(1) << 29);
		imp = $signed({2'b00, rnd[62:30]});
		sum = (VEL_W+3)'(v) + (neg ? -imp : imp);
		if (sum > $signed({3'b000, 32'h7FFF_FFFF}))
			return 32'sh7FFF_FFFF;
		else if (sum < $signed({3'b111, 32'h8000_0000}))
			return 32'sh8000_0000;
		else
			return sum[VEL_W-1:0];
	endfunction

endpackage

// File: sv/sgi_if.sv
// Request and result channel interfaces of the gravity impulse block.
`timescale 1ns / 1ps
interface sgi_in_if;
	import sgi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        body_x;
	logic [POS_W-1:0]        body_y;
	logic signed [VEL_W-1:0] vel_x_in;
	logic signed [VEL_W-1:0] vel_y_in;
	logic [STEP_W-1:0]       step_ms;
	modport source (output valid, body_x, body_y, vel_x_in, vel_y_in, step_ms, input ready);
	modport sink (input valid, body_x, body_y, vel_x_in, vel_y_in, step_ms, output ready);
endinterface

interface sgi_out_if;
	import sgi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x_out;
	logic signed [VEL_W-1:0] vel_y_out;
	logic                    swallowed;
	logic                    in_reach;
	modport source (output valid, vel_x_out, vel_y_out, swallowed, in_reach, input ready);
	modport sink (input valid, vel_x_out, vel_y_out, swallowed, in_reach, output ready);
endinterface

// File: sv/softened_gravity_impulse.sv
// Top level: pipelined softened gravity impulse on a wrapping world.
//
// A body request on the body channel carries position, velocity and time
// step; one result per request leaves on the result channel with the new
// velocity and the swallowed / in-reach flags. Registers are written through
// cfg_we / cfg_index / cfg_data; the user writes them only while no request
// is in flight, which the block does not enforce. A request enters stage 1 at
// the accepting edge and passes 61 pipeline stages, then the output register.
// Throughput: one request per cycle while body.ready is high. The depth is set
// by the bit-per-stage square root (26 stages) followed by the bit-per-stage
// unit-vector divide (30 stages); the impulse divide runs beside the root.
// Reset clears all valid bits and loads the register defaults. No request is
// lost to a stall: one more result drops into a skid entry, then the whole
// pipeline holds and body.ready falls until the skid drains.
`timescale 1ns / 1ps
module softened_gravity_impulse
	import sgi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	sgi_in_if.sink           body,
	sgi_out_if.source        result
);

	logic [CFG_W-1:0] hole_x_q, hole_y_q, width_q, height_q, radius_q, pull_q, reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_x_q <= '0;
			hole_y_q <= '0;
			width_q  <= CFG_W'(1024000);
			height_q <= CFG_W'(1024000);
			radius_q <= CFG_W'(10240);
			pull_q   <= CFG_W'(12800);
			reach_q  <= CFG_W'(204800);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLE_X:       hole_x_q <= cfg_data;
				REG_HOLE_Y:       hole_y_q <= cfg_data;
				REG_WORLD_WIDTH:  width_q  <= cfg_data;
				REG_WORLD_HEIGHT: height_q <= cfg_data;
				REG_HOLE_RADIUS:  radius_q <= cfg_data;
				REG_PULL:         pull_q   <= cfg_data;
				REG_REACH:        reach_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [OFS_W-1:0] fold(
		input logic [POS_W-1:0] hole,
		input logic [POS_W-1:0] pos,
		input logic [CFG_W-1:0] period
	);
		logic signed [OFS_W-1:0] diff, half, per;
		diff = $signed({2'b00, hole}) - $signed({2'b00, pos});
		half = $signed({3'b000, period[CFG_W-1:1]});
		per  = $signed({2'b00, period});
		if (diff > half)
			diff = diff - per;
		else if (diff < -half)
			diff = diff + per;
		return diff;
	endfunction

	// Work of one pipeline stage; idx is fixed per stage at elaboration
	function automatic pipe_t stage_fn(input pipe_t p, input int idx);
		pipe_t              q;
		int                 j;
		logic [2*ROOT_W:0]  delta;
		logic [NUM_W+24:0]  dsh;
		logic [UREM_W-1:0]  ush;
		logic [MAG_W-1:0]   mx, my;
		logic [UNIT_QW:0]   ux, uy;
		logic [ACC_QW:0]    acc;
		q = p;
		if (idx == ST_FOLD) begin
			q.dx = fold(hole_x_q, p.bx, width_q);
			q.dy = fold(hole_y_q, p.by, height_q);
		end
		if (idx == ST_SQUARE) begin
			mx = mag_of(p.dx);
			my = mag_of(p.dy);
			q.sqx = {25'd0, mx} * {25'd0, mx};
			q.sqy = {25'd0, my} * {25'd0, my};
			q.r2  = {24'd0, radius_q} * {24'd0, radius_q};
			q.rr2 = {24'd0, reach_q} * {24'd0, reach_q};
			q.sp  = {10'd0, pull_q} * {24'd0, p.step};
		end
		if (idx == ST_CMP) begin
			q.d2 = {1'b0, p.sqx} + {1'b0, p.sqy};
			q.in_reach  = !(q.d2 > {3'b000, p.rr2});
			q.swallowed = q.in_reach && (q.d2 < {3'b000, p.r2});
			q.bypass    = !q.in_reach || q.swallowed;
			q.soft_d2 = (q.d2 > {1'b0, p.r2, 2'b00}) ? q.d2 : {1'b0, p.r2, 2'b00};
			if (q.soft_d2 == '0)
				q.soft_d2 = D2_W'(1);
			q.num = {p.sp, 24'd0};
		end
		if (idx == ST_ITER) begin
			q.sq_rem  = p.d2;
			q.root    = '0;
			q.acc_rem = p.num;
			q.acc_q   = '0;
			q.acc_cap = ({25'd0, p.num} >= ((NUM_W+25)'(p.soft_d2) << ACC_QW));
		end
		if (idx >= ST_ITER && idx <= SQ_LAST) begin
			j = SQ_LAST - idx;
			delta = ((2*ROOT_W+1)'(q.root) << (j + 1)) + ((2*ROOT_W+1)'(1) << (2 * j));
			if ({2'b00, q.sq_rem} >= delta) begin
				q.sq_rem = q.sq_rem - delta[D2_W-1:0];
				q.root[j] = 1'b1;
			end
		end
		if (idx >= ST_ITER && idx <= ACC_LAST) begin
			j = ACC_LAST - idx;
			dsh = (NUM_W+25)'(q.soft_d2) << j;
			if ({25'd0, q.acc_rem} >= dsh) begin
				q.acc_rem = q.acc_rem - dsh[NUM_W-1:0];
				q.acc_q[j] = 1'b1;
			end
		end
		if (idx == U_FIRST) begin
			mx = mag_of(p.dx);
			my = mag_of(p.dy);
			q.ux_rem  = UREM_W'(mx) << UNIT_QW;
			q.uy_rem  = UREM_W'(my) << UNIT_QW;
			q.ux_q    = '0;
			q.uy_q    = '0;
			q.ux_full = ({1'b0, mx} >= p.root) && (p.root != '0);
			q.uy_full = ({1'b0, my} >= p.root) && (p.root != '0);
		end
		if (idx >= U_FIRST && idx <= U_LAST) begin
			j = U_LAST - idx;
			ush = UREM_W'(q.root) << j;
			if (q.ux_rem >= ush) begin
				q.ux_rem = q.ux_rem - ush;
				q.ux_q[j] = 1'b1;
			end
			if (q.uy_rem >= ush) begin
				q.uy_rem = q.uy_rem - ush;
				q.uy_q[j] = 1'b1;
			end
		end
		if (idx == ST_PROD) begin
			// zero distance means zero unit offset
			acc = p.acc_cap ? (ACC_QW+1)'(1) << ACC_QW : {1'b0, p.acc_q};
			ux = (p.root == '0) ? '0 : p.ux_full ? (UNIT_QW+1)'(1) << UNIT_QW : {1'b0, p.ux_q};
			uy = (p.root == '0) ? '0 : p.uy_full ? (UNIT_QW+1)'(1) << UNIT_QW : {1'b0, p.uy_q};
			q.px = {31'd0, acc} * {33'd0, ux};
			q.py = {31'd0, acc} * {33'd0, uy};
		end
		if (idx == ST_SUM) begin
			if (p.bypass) begin
				q.vx_out = p.vx;
				q.vy_out = p.vy;
			end else begin
				q.vx_out = apply_imp(p.vx, p.dx < 0, p.px);
				q.vy_out = apply_imp(p.vy, p.dy < 0, p.py);
			end
		end
		return q;
	endfunction

	pipe_t p_in;
	pipe_t p_s [1:PIPE_DEPTH];
	logic  v_s [1:PIPE_DEPTH];
	logic  adv;
	logic  out_v_q, sk_v_q;
	res_t  out_q, sk_q, fin;

	always_comb begin
		p_in      = '0;
		p_in.bx   = body.body_x;
		p_in.by   = body.body_y;
		p_in.step = body.step_ms;
		p_in.vx   = body.vel_x_in;
		p_in.vy   = body.vel_y_in;
	end

	assign adv        = !sk_v_q;
	assign body.ready = adv;

	for (genvar i = 1; i <= PIPE_DEPTH; i++) begin : g_stage
		pipe_t prev;
		logic  prev_v;
		if (i == 1) begin : g_head
			assign prev   = p_in;
			assign prev_v = body.valid;
		end else begin : g_body
			assign prev   = p_s[i-1];
			assign prev_v = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (adv)
				v_s[i] <= prev_v;
		end

		always_ff @(posedge clk) begin
			if (adv)
				p_s[i] <= stage_fn(prev, i);
		end
	end

	always_comb begin
		fin.vx        = p_s[PIPE_DEPTH].vx_out;
		fin.vy        = p_s[PIPE_DEPTH].vy_out;
		fin.swallowed = p_s[PIPE_DEPTH].swallowed;
		fin.in_reach  = p_s[PIPE_DEPTH].in_reach;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q <= sk_v_q || v_s[PIPE_DEPTH];
			sk_v_q  <= 1'b0;
		end else if (adv && v_s[PIPE_DEPTH]) begin
			// receiver holds: park the request leaving the pipe
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready)
			out_q <= sk_v_q ? sk_q : fin;
		else if (adv && v_s[PIPE_DEPTH])
			sk_q <= fin;
	end

	assign result.valid     = out_v_q;
	assign result.vel_x_out = out_q.vx;
	assign result.vel_y_out = out_q.vy;
	assign result.swallowed = out_q.swallowed;
	assign result.in_reach  = out_q.in_reach;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry valid without an output result");

	a_swallow_in_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.swallowed) |-> out_q.in_reach)
		else $error("swallowed body reported out of reach");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s[PIPE_DEPTH]) && $stable(v_s[1])))
		else $error("pipeline moved while stalled");

endmodule

// File: tb/softened_gravity_impulse_tb.sv
// Self-checking testbench of the softened gravity impulse block.
`timescale 1ns / 1ps
module softened_gravity_impulse_tb;
	import sgi_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int ITEMS_PER_PHASE = 230;

	typedef struct {
		logic [POS_W-1:0]        bx;
		logic [POS_W-1:0]        by;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [STEP_W-1:0]       step;
	} body_req_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sgi_in_if  body ();
	sgi_out_if result ();

	softened_gravity_impulse u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.body     (body.sink),
		.result   (result.source)
	);

	// Register shadow
	logic [CFG_W-1:0] sh_hole_x, sh_hole_y, sh_width, sh_height;
	logic [CFG_W-1:0] sh_radius, sh_pull, sh_reach;

	body_req_t pending_q[$];
	res_t      velocity_q[$];
	int        err_count;
	int        cycle_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	logic      req_taken;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		err_count++;
	endtask

	function automatic longint fold(input longint diff, input longint unsigned period);
		longint half;
		half = longint'(period >> 1);
		if (diff > half)
			return diff - longint'(period);
		else if (diff < -half)
			return diff + longint'(period);
		return diff;
	endfunction

	function automatic logic signed [VEL_W-1:0] clamp_vel(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[VEL_W-1:0];
	endfunction

	function automatic longint pull_axis(input longint diff, input longint unsigned dist_v,
			input longint unsigned acc);
		longint unsigned mag, unit, prod;
		if (dist_v == 0)
			return 0;
		mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
		unit = (mag << 30) / dist_v;
		if (unit > (64'd1 << 30))
			unit = 64'd1 << 30;
		prod = (acc * unit + (64'd1 << 29)) >> 30;
		return (diff < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic res_t predict_velocity(input body_req_t b);
		res_t r;
		longint dx, dy;
		longint unsigned d2, r2, soft_d2, acc, root, rem, bit_v;
		r.vx = b.vx;
		r.vy = b.vy;
		r.swallowed = 1'b0;
		r.in_reach  = 1'b0;
		dx = fold(longint'(sh_hole_x) - longint'(b.bx), sh_width);
		dy = fold(longint'(sh_hole_y) - longint'(b.by), sh_height);
		d2 = longint'(dx * dx) + longint'(dy * dy);
		r2 = longint'(sh_radius) * longint'(sh_radius);
		if (d2 > longint'(sh_reach) * longint'(sh_reach))
			return r;
		r.in_reach = 1'b1;
		if (d2 < r2) begin
			r.swallowed = 1'b1;
			return r;
		end
		soft_d2 = 4 * r2;
		if (d2 > soft_d2)
			soft_d2 = d2;
		if (soft_d2 == 0)
			soft_d2 = 1;
		acc = ((longint'(sh_pull) * longint'(b.step)) << 24) / soft_d2;
		if (acc > (64'd1 << 32))
			acc = 64'd1 << 32;
		// bit-by-bit integer square root
		root  = 0;
		rem   = d2;
		bit_v = 64'd1 << 62;
		while (bit_v > rem)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= root + bit_v) begin
				rem  -= root + bit_v;
				root  = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		r.vx = clamp_vel(longint'(b.vx) + pull_axis(dx, root, acc));
		r.vy = clamp_vel(longint'(b.vy) + pull_axis(dy, root, acc));
		return r;
	endfunction

	// Accept requests, predict, check results, watch the clock budget
	always @(posedge clk) begin
		res_t      exp_r;
		body_req_t b;
		req_taken <= body.valid && body.ready;
		if (body.valid && body.ready) begin
			b.bx = body.body_x;
			b.by = body.body_y;
			b.vx = body.vel_x_in;
			b.vy = body.vel_y_in;
			b.step = body.step_ms;
			velocity_q.push_back(predict_velocity(b));
		end
		if (result.valid && result.ready) begin
			if (velocity_q.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				exp_r = velocity_q.pop_front();
				if (result.vel_x_out !== exp_r.vx)
					report($sformatf("vel_x_out %0d expected %0d", result.vel_x_out, exp_r.vx));
				if (result.vel_y_out !== exp_r.vy)
					report($sformatf("vel_y_out %0d expected %0d", result.vel_y_out, exp_r.vy));
				if (result.swallowed !== exp_r.swallowed)
					report($sformatf("swallowed %b expected %b", result.swallowed,
						exp_r.swallowed));
				if (result.in_reach !== exp_r.in_reach)
					report($sformatf("in_reach %b expected %b", result.in_reach,
						exp_r.in_reach));
			end
		end
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("softened_gravity_impulse_tb: FAIL");
			$finish;
		end
	end

	// Request driver and result back-pressure
	always @(negedge clk) begin
		body_req_t b;
		if (arst_n) begin
			if (!body.valid || req_taken) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					b = pending_q.pop_front();
					body.valid    <= 1'b1;
					body.body_x   <= b.bx;
					body.body_y   <= b.by;
					body.vel_x_in <= b.vx;
					body.vel_y_in <= b.vy;
					body.step_ms  <= b.step;
				end else begin
					body.valid <= 1'b0;
				end
			end
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			REG_HOLE_X:       sh_hole_x = val;
			REG_HOLE_Y:       sh_hole_y = val;
			REG_WORLD_WIDTH:  sh_width  = val;
			REG_WORLD_HEIGHT: sh_height = val;
			REG_HOLE_RADIUS:  sh_radius = val;
			REG_PULL:         sh_pull   = val;
			REG_REACH:        sh_reach  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic setup(input logic [CFG_W-1:0] hx, hy, w, h, rad, pull, reach);
		write_reg(REG_HOLE_X, hx);
		write_reg(REG_HOLE_Y, hy);
		write_reg(REG_WORLD_WIDTH, w);
		write_reg(REG_WORLD_HEIGHT, h);
		write_reg(REG_HOLE_RADIUS, rad);
		write_reg(REG_PULL, pull);
		write_reg(REG_REACH, reach);
	endtask

	// Hold until every request has been answered and the pipeline is empty
	task automatic wait_idle();
		while (pending_q.size() != 0 || velocity_q.size() != 0 || body.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_body(input logic [POS_W-1:0] bx, by, input logic [VEL_W-1:0] vx, vy,
			input logic [STEP_W-1:0] step);
		body_req_t b;
		b.bx = bx;
		b.by = by;
		b.vx = vx;
		b.vy = vy;
		b.step = step;
		pending_q.push_back(b);
	endtask

	function automatic logic [VEL_W-1:0] rand_vel();
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF - $urandom_range(4095);
			1: return 32'h8000_0000 + $urandom_range(4095);
			2: return $urandom_range(1 << 20) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random_body();
		int span, ox, oy;
		logic [STEP_W-1:0] step;
		span = (sh_reach > (1 << 22)) ? (1 << 22) : int'(sh_reach) + 2;
		step = ($urandom_range(7) == 0) ? 10'd1023 : 10'($urandom_range(1023));
		if ($urandom_range(99) < 75) begin
			ox = int'($urandom_range(2 * span)) - span;
			oy = int'($urandom_range(2 * span)) - span;
			if ($urandom_range(9) == 0) begin
				ox = ox / 64;
				oy = oy / 64;
			end
			add_body(POS_W'(int'(sh_hole_x) + ox), POS_W'(int'(sh_hole_y) + oy),
				rand_vel(), rand_vel(), step);
		end else begin
			add_body(POS_W'($urandom), POS_W'($urandom), rand_vel(), rand_vel(), step);
		end
	endtask

	initial begin
		int phase;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_HOLE_X;
		cfg_data  = '0;
		body.valid    = 1'b0;
		body.body_x   = '0;
		body.body_y   = '0;
		body.vel_x_in = '0;
		body.vel_y_in = '0;
		body.step_ms  = '0;
		result.ready  = 1'b0;
		req_taken     = 1'b0;
		err_count     = 0;
		cycle_count   = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sh_hole_x = 0;
		sh_hole_y = 0;
		sh_width  = 1024000;
		sh_height = 1024000;
		sh_radius = 10240;
		sh_pull   = 12800;
		sh_reach  = 204800;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests on reset defaults
		add_body(24'd0, 24'd0, 32'd100, -32'sd100, 10'd5);            // at the hole
		add_body(24'd204800, 24'd0, 32'd0, 32'd0, 10'd1023);          // exactly on reach
		add_body(24'd204801, 24'd0, 32'd7, 32'd9, 10'd1023);          // just past reach
		add_body(24'd10240, 24'd0, 32'd0, 32'd0, 10'd1);              // on hole radius
		add_body(24'd10239, 24'd0, 32'd0, 32'd0, 10'd1);              // just inside
		add_body(24'd20480, 24'd0, 32'd0, 32'd0, 10'd1023);           // softening edge
		add_body(24'd1024000 - 24'd30000, 24'd40000, 32'd0, 32'd0, 10'd1023); // wraps
		add_body(24'd30000, 24'd30000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1023);
		add_body(24'd1023000, 24'd1023000, 32'h8000_0000, 32'h8000_0000, 10'd1023);
		add_body(24'd50000, 24'd60000, 32'd12345, -32'sd54321, 10'd0);  // zero step
		add_body(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'd1, 10'd512); // far beyond world
		add_body(24'd0, 24'hFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 10'h2AA);
		add_body(24'd100000, 24'd0, 32'd0, 32'd0, 10'd1023);
		add_body(24'd0, 24'd100000, 32'd0, 32'd0, 10'd1023);
		wait_idle();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setup(24'd512000, 24'd512000, 24'd1024000, 24'd1024000,
					24'd10240, 24'hFF_FFFF, 24'd204800);
				1: setup(24'd100, 24'd200, 24'd256, 24'd256, 24'd1, 24'd12800, 24'hFF_FFFF);
				2: setup(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
					24'hFF_FFFF, 24'd1, 24'hFF_FFFF);
				3: setup(24'd300000, 24'd5000, 24'd1024000, 24'd700000, 24'd1, 24'd0, 24'd0);
				4: setup(24'd0, 24'd0, 24'd2000000, 24'd300, 24'd64, 24'd65536, 24'd50000);
				default: setup(24'd700000, 24'd123456, 24'd1000000, 24'd900000,
					24'd2560, 24'd12800, 24'd300000);
			endcase
			if (phase == 3)
				write_reg(REG_SPARE, 24'hAB_CDEF);   // unknown index, must be ignored
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			repeat (ITEMS_PER_PHASE) add_random_body();
			if (phase == 5) begin
				// drop all idling for a burst after a full drain
				wait_idle();
				send_idle_pct = 0;
				recv_stall_pct = 0;
				repeat (40) add_random_body();
			end
			wait_idle();
		end

		if (err_count == 0)
			$display("softened_gravity_impulse_tb: PASS");
		else
			$display("softened_gravity_impulse_tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/sgi_pkg.sv
sv/sgi_if.sv
sv/softened_gravity_impulse.sv
tb/softened_gravity_impulse_tb.sv
